// ===== design/fls_pkg.sv =====
// ============================================================================
// fls_pkg - shared types and constants for the fuzzy line steering block
// Field widths, register map, reset values and pipeline payload structs.
// ============================================================================
package fls_pkg;

    // Widths of samples and fuzzy grades
    localparam int SAMPLE_BITS = 10;
    localparam int GRADE_BITS  = 8;

    // Fixed field widths
    localparam int LIMIT_BITS  = 10;
    localparam int START_BITS  = 10;
    localparam int SPAN_BITS   = 9;
    localparam int DUTY_BITS   = 8;
    localparam int STEER_BITS  = 7;
    localparam int STEER_QBITS = 6;     // |steer| <= 50
    localparam int ADDR_BITS   = 5;
    localparam int DATA_BITS   = 32;

    // Derived widths
    localparam int DIFF_BITS = ((SAMPLE_BITS > START_BITS) ? SAMPLE_BITS : START_BITS) + 1;
    localparam int DEN_BITS  = GRADE_BITS + 3;            // sum of five strengths
    localparam int MAG_BITS  = GRADE_BITS + 3;            // |signed rule sum|
    localparam int NUM_BITS  = DEN_BITS + STEER_QBITS;    // 25 * |rule sum|

    localparam logic [GRADE_BITS:0]    GRADE_ONE    = {1'b1, {GRADE_BITS{1'b0}}};
    localparam logic [SPAN_BITS-1:0]   SPAN_ONE     = {{(SPAN_BITS-1){1'b0}}, 1'b1};
    localparam logic [STEER_QBITS-1:0] STEER_CENTER = 6'd10;
    localparam logic [4:0]             SOFT_WEIGHT  = 5'd25;

    // Reset values
    localparam logic [LIMIT_BITS-1:0] RST_MIDDLE_BLACK_LIMIT = 10'd100;
    localparam logic [START_BITS-1:0] RST_RIGHT_RAMP_START   = 10'd95;
    localparam logic [SPAN_BITS-1:0]  RST_RIGHT_RAMP_SPAN    = 9'd110;
    localparam logic [START_BITS-1:0] RST_LEFT_RAMP_START    = 10'd56;
    localparam logic [SPAN_BITS-1:0]  RST_LEFT_RAMP_SPAN     = 9'd64;
    localparam logic [DUTY_BITS-1:0]  RST_BASE_DUTY          = 8'd150;
    localparam logic [DUTY_BITS-1:0]  RST_BLACK_DUTY         = 8'd250;
    localparam logic [DUTY_BITS-1:0]  RST_CENTER_DUTY        = 8'd200;

    // Register map, word index
    typedef enum logic [ADDR_BITS-3:0] {
        IDX_MIDDLE_BLACK_LIMIT,
        IDX_RIGHT_RAMP_START,
        IDX_RIGHT_RAMP_SPAN,
        IDX_LEFT_RAMP_START,
        IDX_LEFT_RAMP_SPAN,
        IDX_BASE_DUTY,
        IDX_BLACK_DUTY,
        IDX_CENTER_DUTY
    } t_reg_idx;

    // Where a sample sits on its ramps
    typedef enum logic [1:0] {
        RGN_BLACK,      // below the ramps
        RGN_GRAY,       // black fading to gray
        RGN_FADE,       // gray fading to white
        RGN_WHITE       // past the ramps
    } t_region;

    typedef logic [GRADE_BITS:0] t_grade;

    // One side while its ramp fraction is divided out
    typedef struct packed {
        t_region               region;
        logic [SPAN_BITS-1:0]  rem;
        logic [GRADE_BITS-1:0] quo;
    } t_side;

    typedef struct packed {
        t_grade black;
        t_grade gray;
        t_grade white;
    } t_grades;

    // Steer division payload
    typedef struct packed {
        logic [NUM_BITS-1:0]    rem;
        logic [DEN_BITS-1:0]    den;
        logic [STEER_QBITS-1:0] quo;
        logic                   neg;
        logic                   none;
        logic                   black;
    } t_steer;

endpackage

// ===== design/fuzzy_line_steering.sv =====
// ============================================================================
// fuzzy_line_steering - fuzzy controller for a line-following robot
// Grades left/right reflectance, fires five min-rules, averages the steer
// and turns it into two saturated wheel duties.
// ============================================================================
// Usage:
//   Command channel: drive the three samples with start high for one cycle;
//   the transfer happens on the clock edge where start is high and busy is
//   low. busy is never raised, so a new sample triple may be given every
//   cycle.
//   Result channel: o_done is high for exactly one cycle, together with
//   o_right_duty, o_left_duty, o_steer_value and o_no_rule_fired. Results
//   come out in input order.
//   Throughput: one item per clock. The pipeline holds two bit-serial
//   restoring dividers laid out as pipeline stages: 8 stages for the ramp
//   fractions (one quotient bit each, left and right side in parallel) and
//   6 stages for the weighted-average steer, plus 5 stages around them.
//   The receiver cannot stall; results are simply presented.
//   Configuration: APB port, one 32-bit word per register at 4*index.
//   pready is tied high; writes take effect on the access cycle edge.
//   Registers may only change while no item is in flight.
//   Reset (synchronous, active low) loads the register defaults and
//   empties the pipeline; no clearing pass is needed.
// ============================================================================
module fuzzy_line_steering (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // configuration
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [fls_pkg::ADDR_BITS-1:0]        paddr,
    input  logic [fls_pkg::DATA_BITS-1:0]        pwdata,
    output logic [fls_pkg::DATA_BITS-1:0]        prdata,
    output logic                                 pready,
    // command
    input  logic                                 start,
    output logic                                 busy,
    input  logic [fls_pkg::SAMPLE_BITS-1:0]      i_left_sample,
    input  logic [fls_pkg::SAMPLE_BITS-1:0]      i_right_sample,
    input  logic [fls_pkg::SAMPLE_BITS-1:0]      i_middle_sample,
    // result
    output logic                                 o_done,
    output logic [fls_pkg::DUTY_BITS-1:0]        o_right_duty,
    output logic [fls_pkg::DUTY_BITS-1:0]        o_left_duty,
    output logic signed [fls_pkg::STEER_BITS-1:0] o_steer_value,
    output logic                                 o_no_rule_fired
);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [fls_pkg::LIMIT_BITS-1:0] r_middle_black_limit;
    logic [fls_pkg::START_BITS-1:0] r_right_ramp_start;
    logic [fls_pkg::SPAN_BITS-1:0]  r_right_ramp_span;
    logic [fls_pkg::START_BITS-1:0] r_left_ramp_start;
    logic [fls_pkg::SPAN_BITS-1:0]  r_left_ramp_span;
    logic [fls_pkg::DUTY_BITS-1:0]  r_base_duty;
    logic [fls_pkg::DUTY_BITS-1:0]  r_black_duty;
    logic [fls_pkg::DUTY_BITS-1:0]  r_center_duty;

    logic                           cfg_wr;
    fls_pkg::t_reg_idx              cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite & pready;
    assign cfg_idx = fls_pkg::t_reg_idx'(paddr[fls_pkg::ADDR_BITS-1:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_middle_black_limit <= fls_pkg::RST_MIDDLE_BLACK_LIMIT;
            r_right_ramp_start   <= fls_pkg::RST_RIGHT_RAMP_START;
            r_right_ramp_span    <= fls_pkg::RST_RIGHT_RAMP_SPAN;
            r_left_ramp_start    <= fls_pkg::RST_LEFT_RAMP_START;
            r_left_ramp_span     <= fls_pkg::RST_LEFT_RAMP_SPAN;
            r_base_duty          <= fls_pkg::RST_BASE_DUTY;
            r_black_duty         <= fls_pkg::RST_BLACK_DUTY;
            r_center_duty        <= fls_pkg::RST_CENTER_DUTY;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                fls_pkg::IDX_MIDDLE_BLACK_LIMIT:
                    r_middle_black_limit <= pwdata[fls_pkg::LIMIT_BITS-1:0];
                fls_pkg::IDX_RIGHT_RAMP_START:
                    r_right_ramp_start <= pwdata[fls_pkg::START_BITS-1:0];
                fls_pkg::IDX_RIGHT_RAMP_SPAN:
                    r_right_ramp_span <= pwdata[fls_pkg::SPAN_BITS-1:0];
                fls_pkg::IDX_LEFT_RAMP_START:
                    r_left_ramp_start <= pwdata[fls_pkg::START_BITS-1:0];
                fls_pkg::IDX_LEFT_RAMP_SPAN:
                    r_left_ramp_span <= pwdata[fls_pkg::SPAN_BITS-1:0];
                fls_pkg::IDX_BASE_DUTY:
                    r_base_duty <= pwdata[fls_pkg::DUTY_BITS-1:0];
                fls_pkg::IDX_BLACK_DUTY:
                    r_black_duty <= pwdata[fls_pkg::DUTY_BITS-1:0];
                fls_pkg::IDX_CENTER_DUTY:
                    r_center_duty <= pwdata[fls_pkg::DUTY_BITS-1:0];
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (cfg_idx)
            fls_pkg::IDX_MIDDLE_BLACK_LIMIT:
                prdata[fls_pkg::LIMIT_BITS-1:0] = r_middle_black_limit;
            fls_pkg::IDX_RIGHT_RAMP_START:
                prdata[fls_pkg::START_BITS-1:0] = r_right_ramp_start;
            fls_pkg::IDX_RIGHT_RAMP_SPAN:
                prdata[fls_pkg::SPAN_BITS-1:0] = r_right_ramp_span;
            fls_pkg::IDX_LEFT_RAMP_START:
                prdata[fls_pkg::START_BITS-1:0] = r_left_ramp_start;
            fls_pkg::IDX_LEFT_RAMP_SPAN:
                prdata[fls_pkg::SPAN_BITS-1:0] = r_left_ramp_span;
            fls_pkg::IDX_BASE_DUTY:
                prdata[fls_pkg::DUTY_BITS-1:0] = r_base_duty;
            fls_pkg::IDX_BLACK_DUTY:
                prdata[fls_pkg::DUTY_BITS-1:0] = r_black_duty;
            fls_pkg::IDX_CENTER_DUTY:
                prdata[fls_pkg::DUTY_BITS-1:0] = r_center_duty;
        endcase
    end

    // A span written as zero behaves as one
    logic [fls_pkg::SPAN_BITS-1:0] left_span;
    logic [fls_pkg::SPAN_BITS-1:0] right_span;

    assign left_span  = (r_left_ramp_span  == '0) ? fls_pkg::SPAN_ONE : r_left_ramp_span;
    assign right_span = (r_right_ramp_span == '0) ? fls_pkg::SPAN_ONE : r_right_ramp_span;

    // ------------------------------------------------------------------
    // Helper functions
    // ------------------------------------------------------------------

    // Locate the sample on its ramps; rem is the offset into the active ramp
    function automatic fls_pkg::t_side side_start(
        input logic [fls_pkg::SAMPLE_BITS-1:0] x,
        input logic [fls_pkg::START_BITS-1:0]  s,
        input logic [fls_pkg::SPAN_BITS-1:0]   w
    );
        logic [fls_pkg::DIFF_BITS-1:0] xe;
        logic [fls_pkg::DIFF_BITS-1:0] se;
        logic [fls_pkg::DIFF_BITS-1:0] we;
        logic [fls_pkg::DIFF_BITS-1:0] w2;
        logic [fls_pkg::DIFF_BITS-1:0] d;
        logic [fls_pkg::DIFF_BITS-1:0] dw;
        fls_pkg::t_side                r;
        xe = {{(fls_pkg::DIFF_BITS-fls_pkg::SAMPLE_BITS){1'b0}}, x};
        se = {{(fls_pkg::DIFF_BITS-fls_pkg::START_BITS){1'b0}}, s};
        we = {{(fls_pkg::DIFF_BITS-fls_pkg::SPAN_BITS){1'b0}}, w};
        w2 = {{(fls_pkg::DIFF_BITS-fls_pkg::SPAN_BITS-1){1'b0}}, w, 1'b0};
        d  = xe - se;
        dw = d - we;
        r.quo = '0;
        if (xe < se) begin
            r.region = fls_pkg::RGN_BLACK;
            r.rem    = '0;
        end else if (d < we) begin
            r.region = fls_pkg::RGN_GRAY;
            r.rem    = d[fls_pkg::SPAN_BITS-1:0];
        end else if (d < w2) begin
            r.region = fls_pkg::RGN_FADE;
            r.rem    = dw[fls_pkg::SPAN_BITS-1:0];
        end else begin
            r.region = fls_pkg::RGN_WHITE;
            r.rem    = '0;
        end
        return r;
    endfunction

    // One restoring step: one quotient bit of rem * ONE / w
    function automatic fls_pkg::t_side side_step(
        input fls_pkg::t_side                a,
        input logic [fls_pkg::SPAN_BITS-1:0] w
    );
        logic [fls_pkg::SPAN_BITS:0] t;
        logic                        ge;
        fls_pkg::t_side              r;
        r  = a;
        t  = {a.rem, 1'b0};
        ge = (t >= {1'b0, w});
        if (ge) begin
            t = t - {1'b0, w};
        end
        r.rem = t[fls_pkg::SPAN_BITS-1:0];
        r.quo = {a.quo[fls_pkg::GRADE_BITS-2:0], ge};
        return r;
    endfunction

    function automatic fls_pkg::t_grades side_grades(input fls_pkg::t_side a);
        fls_pkg::t_grade  q;
        fls_pkg::t_grades g;
        q = {1'b0, a.quo};
        g = '0;
        case (a.region)
            fls_pkg::RGN_BLACK: g.black = fls_pkg::GRADE_ONE;
            fls_pkg::RGN_GRAY: begin
                g.gray  = q;
                g.black = fls_pkg::GRADE_ONE - q;
            end
            fls_pkg::RGN_FADE: begin
                g.white = q;
                g.gray  = fls_pkg::GRADE_ONE - q;
            end
            default: g.white = fls_pkg::GRADE_ONE;
        endcase
        return g;
    endfunction

    function automatic fls_pkg::t_grade gmin(
        input fls_pkg::t_grade a,
        input fls_pkg::t_grade b
    );
        return (a < b) ? a : b;
    endfunction

    // Clamp a 10-bit signed duty to 0..255
    function automatic logic [fls_pkg::DUTY_BITS-1:0] sat_duty(
        input logic [fls_pkg::DUTY_BITS+1:0] v
    );
        logic [fls_pkg::DUTY_BITS-1:0] r;
        if (v[fls_pkg::DUTY_BITS+1]) begin
            r = '0;
        end else if (v[fls_pkg::DUTY_BITS]) begin
            r = '1;
        end else begin
            r = v[fls_pkg::DUTY_BITS-1:0];
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Stage 0 and ramp division stages 1..GRADE_BITS
    // ------------------------------------------------------------------
    logic           r_dv_valid [fls_pkg::GRADE_BITS+1];
    logic           r_dv_black [fls_pkg::GRADE_BITS+1];
    fls_pkg::t_side r_dv_left  [fls_pkg::GRADE_BITS+1];
    fls_pkg::t_side r_dv_right [fls_pkg::GRADE_BITS+1];

    logic                          in_xfer;
    logic [fls_pkg::DIFF_BITS-1:0] mid_ext;
    logic [fls_pkg::DIFF_BITS-1:0] limit_ext;

    assign busy      = 1'b0;
    assign in_xfer   = start & ~busy;
    assign mid_ext   = {{(fls_pkg::DIFF_BITS-fls_pkg::SAMPLE_BITS){1'b0}}, i_middle_sample};
    assign limit_ext = {{(fls_pkg::DIFF_BITS-fls_pkg::LIMIT_BITS){1'b0}}, r_middle_black_limit};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv_valid[0] <= 1'b0;
        end else begin
            r_dv_valid[0] <= in_xfer;
        end
        r_dv_black[0] <= (mid_ext <= limit_ext);
        r_dv_left[0]  <= side_start(i_left_sample, r_left_ramp_start, left_span);
        r_dv_right[0] <= side_start(i_right_sample, r_right_ramp_start, right_span);
    end

    for (genvar j = 0; j < fls_pkg::GRADE_BITS; j++) begin : g_ramp_div
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv_valid[j+1] <= 1'b0;
            end else begin
                r_dv_valid[j+1] <= r_dv_valid[j];
            end
            r_dv_black[j+1] <= r_dv_black[j];
            r_dv_left[j+1]  <= side_step(r_dv_left[j], left_span);
            r_dv_right[j+1] <= side_step(r_dv_right[j], right_span);
        end
    end

    // ------------------------------------------------------------------
    // Rule strengths
    // ------------------------------------------------------------------
    fls_pkg::t_grades lg;
    fls_pkg::t_grades rg;

    assign lg = side_grades(r_dv_left[fls_pkg::GRADE_BITS]);
    assign rg = side_grades(r_dv_right[fls_pkg::GRADE_BITS]);

    logic            r_b_valid;
    logic            r_b_black;
    fls_pkg::t_grade r_b_fwd, r_b_sl, r_b_hl, r_b_sr, r_b_hr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else begin
            r_b_valid <= r_dv_valid[fls_pkg::GRADE_BITS];
        end
        r_b_black <= r_dv_black[fls_pkg::GRADE_BITS];
        r_b_fwd   <= gmin(rg.white, lg.white);
        r_b_sl    <= gmin(lg.gray,  rg.white);
        r_b_hl    <= gmin(rg.white, lg.black);
        r_b_sr    <= gmin(rg.gray,  lg.white);
        r_b_hr    <= gmin(rg.black, lg.white);
    end

    // ------------------------------------------------------------------
    // Rule sums: total strength and signed weight sum in units of 25
    // ------------------------------------------------------------------
    logic [fls_pkg::MAG_BITS-1:0] pos_sum;
    logic [fls_pkg::MAG_BITS-1:0] neg_sum;
    logic [fls_pkg::DEN_BITS-1:0] den_sum;

    assign pos_sum = {2'b00, r_b_sr} + {1'b0, r_b_hr, 1'b0};
    assign neg_sum = {2'b00, r_b_sl} + {1'b0, r_b_hl, 1'b0};
    assign den_sum = {2'b00, r_b_fwd} + {2'b00, r_b_sl} + {2'b00, r_b_hl}
                   + {2'b00, r_b_sr} + {2'b00, r_b_hr};

    logic                         r_c_valid;
    logic                         r_c_black;
    logic                         r_c_neg;
    logic [fls_pkg::MAG_BITS-1:0] r_c_mag;
    logic [fls_pkg::DEN_BITS-1:0] r_c_den;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid <= 1'b0;
        end else begin
            r_c_valid <= r_b_valid;
        end
        r_c_black <= r_b_black;
        r_c_den   <= den_sum;
        r_c_neg   <= (neg_sum > pos_sum);
        r_c_mag   <= (neg_sum > pos_sum) ? (neg_sum - pos_sum) : (pos_sum - neg_sum);
    end

    // ------------------------------------------------------------------
    // Weight scaling and steer division stages
    // ------------------------------------------------------------------
    logic [fls_pkg::NUM_BITS-1:0] num_abs;

    assign num_abs = {{(fls_pkg::NUM_BITS-fls_pkg::MAG_BITS){1'b0}}, r_c_mag}
                   * {{(fls_pkg::NUM_BITS-5){1'b0}}, fls_pkg::SOFT_WEIGHT};

    logic            r_sd_valid [fls_pkg::STEER_QBITS+1];
    fls_pkg::t_steer r_sd       [fls_pkg::STEER_QBITS+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sd_valid[0] <= 1'b0;
        end else begin
            r_sd_valid[0] <= r_c_valid;
        end
        r_sd[0].rem   <= num_abs;
        r_sd[0].den   <= r_c_den;
        r_sd[0].quo   <= '0;
        r_sd[0].neg   <= r_c_neg;
        r_sd[0].none  <= (r_c_den == '0);
        r_sd[0].black <= r_c_black;
    end

    // Quotient < 64, so the dividend starts below den << STEER_QBITS
    for (genvar k = 0; k < fls_pkg::STEER_QBITS; k++) begin : g_steer_div
        logic [fls_pkg::NUM_BITS-1:0] dsh;
        logic                         ge;
        fls_pkg::t_steer              n_sd;

        assign dsh = {{fls_pkg::STEER_QBITS{1'b0}}, r_sd[k].den}
                     << (fls_pkg::STEER_QBITS - 1 - k);
        assign ge  = (r_sd[k].rem >= dsh);

        always_comb begin
            n_sd     = r_sd[k];
            n_sd.rem = ge ? (r_sd[k].rem - dsh) : r_sd[k].rem;
            n_sd.quo = {r_sd[k].quo[fls_pkg::STEER_QBITS-2:0], ge};
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sd_valid[k+1] <= 1'b0;
            end else begin
                r_sd_valid[k+1] <= r_sd_valid[k];
            end
            r_sd[k+1] <= n_sd;
        end
    end

    // ------------------------------------------------------------------
    // Duty bands and output register
    // ------------------------------------------------------------------
    fls_pkg::t_steer                 sq;
    logic [fls_pkg::STEER_QBITS-1:0] smag;
    logic                            sneg;
    logic [fls_pkg::STEER_BITS-1:0]  smag_ext;
    logic [fls_pkg::STEER_BITS-1:0]  steer;
    logic [fls_pkg::DUTY_BITS+1:0]   base_ext;
    logic [fls_pkg::DUTY_BITS+1:0]   mag_ext;
    logic [fls_pkg::DUTY_BITS+1:0]   duty_up;
    logic [fls_pkg::DUTY_BITS+1:0]   duty_dn;
    logic                            band_lo;
    logic                            band_hi;

    assign sq       = r_sd[fls_pkg::STEER_QBITS];
    // no rule fired forces steer to zero
    assign smag     = sq.none ? '0 : sq.quo;
    assign sneg     = sq.neg & ~sq.none;
    assign smag_ext = {{(fls_pkg::STEER_BITS-fls_pkg::STEER_QBITS){1'b0}}, smag};
    assign steer    = sneg ? ('0 - smag_ext) : smag_ext;
    assign base_ext = {2'b00, r_base_duty};
    assign mag_ext  = {{(fls_pkg::DUTY_BITS+2-fls_pkg::STEER_QBITS){1'b0}}, smag};
    assign duty_up  = base_ext + mag_ext;
    assign duty_dn  = base_ext - mag_ext;
    assign band_lo  = sneg || (smag < fls_pkg::STEER_CENTER);
    assign band_hi  = !sneg && (smag > fls_pkg::STEER_CENTER);

    logic                            r_out_valid;
    logic [fls_pkg::DUTY_BITS-1:0]   r_out_right;
    logic [fls_pkg::DUTY_BITS-1:0]   r_out_left;
    logic [fls_pkg::STEER_BITS-1:0]  r_out_steer;
    logic                            r_out_none;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= r_sd_valid[fls_pkg::STEER_QBITS];
        end
        if (sq.black) begin
            // line under the middle sensor
            r_out_right <= r_black_duty;
            r_out_left  <= r_black_duty;
            r_out_steer <= '0;
            r_out_none  <= 1'b0;
        end else begin
            r_out_steer <= steer;
            r_out_none  <= sq.none;
            if (band_lo) begin
                r_out_right <= sat_duty(duty_up);
                r_out_left  <= sat_duty(duty_dn);
            end else if (band_hi) begin
                r_out_right <= sat_duty(duty_dn);
                r_out_left  <= sat_duty(duty_up);
            end else begin
                r_out_right <= r_center_duty;
                r_out_left  <= r_center_duty;
            end
        end
    end

    assign o_done          = r_out_valid;
    assign o_right_duty    = r_out_right;
    assign o_left_duty     = r_out_left;
    assign o_steer_value   = r_out_steer;
    assign o_no_rule_fired = r_out_none;

endmodule
